[sv/lpfr_pkg.sv]
package lpfr_pkg;

  // Result kinds as they leave on tuser
  typedef enum logic [2:0] {
    KIND_DROPPED  = 3'd0,
    KIND_MISMATCH = 3'd1,
    KIND_PAYLOAD  = 3'd2,
    KIND_EMPTY    = 3'd3,
    KIND_BADLEN   = 3'd4
  } kind_e;

  localparam logic [7:0] FrameOverhead = 8'd4;
  localparam int unsigned LenW = 6;

  // Command from parser to drain. KIND_PAYLOAD means "emit len stored bytes".
  typedef struct packed {
    kind_e           kind;
    logic [7:0]      value;
    logic            ok;
    logic [LenW-1:0] len;
  } cmd_t;

  // Payload store write port
  typedef struct packed {
    logic            en;
    logic [LenW-1:0] addr;
    logic [7:0]      data;
  } wr_t;

  // Drain status back to the parser
  typedef struct packed {
    logic done;
  } drain_stat_t;

endpackage

[sv/lpfr_fifo.sv]
module lpfr_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lpfr_pkg::cmd_t  push_cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output lpfr_pkg::cmd_t  pop_cmd_o
);

  lpfr_pkg::cmd_t entry_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign full_o    = (cnt_q == 2'd2);
  assign valid_o   = (cnt_q != 2'd0);
  assign pop_cmd_o = entry_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

[sv/lpfr_parser.sv]
module lpfr_parser #(
  parameter int unsigned PAYLOAD_MAX = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  rx_valid_i,
  input  logic [7:0]            rx_byte_i,
  output logic                  rx_ready_o,
  input  logic [7:0]            start_byte_i,
  input  logic                  fifo_full_i,
  output logic                  push_o,
  output lpfr_pkg::cmd_t        cmd_o,
  output lpfr_pkg::wr_t         wr_o,
  input  lpfr_pkg::drain_stat_t stat_i
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_LENGTH, PH_INVERSE, PH_PAYLOAD, PH_CHECKSUM, PH_TRAILER
  } phase_e;

  localparam logic [8:0] MaxLen = 9'(PAYLOAD_MAX + 4);

  phase_e                     phase_q;
  logic [7:0]                 frame_len_q;
  logic [lpfr_pkg::LenW-1:0]  pay_len_q;
  logic [lpfr_pkg::LenW-1:0]  pay_cnt_q;
  logic [lpfr_pkg::LenW-1:0]  pay_cnt_inc;
  logic [7:0]                 xor_q;
  logic                       busy_q;    // a payload run is queued or draining
  logic                       acc;
  logic                       bad_len;

  // Store must not be overwritten while the previous frame drains
  assign rx_ready_o  = !fifo_full_i && !(phase_q == PH_PAYLOAD && busy_q);
  assign acc         = rx_valid_i && rx_ready_o;
  assign pay_cnt_inc = pay_cnt_q + 1'b1;
  assign bad_len     = (rx_byte_i < lpfr_pkg::FrameOverhead) || ({1'b0, rx_byte_i} > MaxLen);

  assign wr_o.en   = acc && (phase_q == PH_PAYLOAD);
  assign wr_o.addr = pay_cnt_q;
  assign wr_o.data = rx_byte_i;

  always_comb begin
    push_o       = 1'b0;
    cmd_o.kind   = lpfr_pkg::KIND_DROPPED;
    cmd_o.value  = rx_byte_i;
    cmd_o.ok     = 1'b0;
    cmd_o.len    = pay_len_q;
    unique case (phase_q)
      PH_LENGTH: begin
        push_o     = acc && bad_len;
        cmd_o.kind = lpfr_pkg::KIND_BADLEN;
      end
      PH_INVERSE: begin
        push_o      = acc && ((frame_len_q & rx_byte_i) != 8'd0);
        cmd_o.kind  = lpfr_pkg::KIND_MISMATCH;
        cmd_o.value = frame_len_q;
      end
      PH_PAYLOAD, PH_CHECKSUM: ;
      PH_TRAILER: begin
        push_o     = acc;
        cmd_o.ok   = (xor_q == 8'd0);
        if (pay_len_q == '0) begin
          cmd_o.kind  = lpfr_pkg::KIND_EMPTY;
          cmd_o.value = 8'd0;
        end else begin
          cmd_o.kind = lpfr_pkg::KIND_PAYLOAD;
        end
      end
      default: begin
        push_o = acc && (rx_byte_i != start_byte_i);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      frame_len_q <= 8'd0;
      pay_len_q   <= '0;
      pay_cnt_q   <= '0;
      xor_q       <= 8'd0;
      busy_q      <= 1'b0;
    end else begin
      if (push_o && cmd_o.kind == lpfr_pkg::KIND_PAYLOAD) begin
        busy_q <= 1'b1;
      end else if (stat_i.done) begin
        busy_q <= 1'b0;
      end
      if (acc) begin
        unique case (phase_q)
          PH_LENGTH: begin
            frame_len_q <= rx_byte_i;
            if (bad_len) begin
              phase_q   <= PH_IDLE;
              pay_len_q <= '0;
              pay_cnt_q <= '0;
              xor_q     <= 8'd0;
            end else begin
              pay_len_q <= lpfr_pkg::LenW'(rx_byte_i - lpfr_pkg::FrameOverhead);
              pay_cnt_q <= '0;
              xor_q     <= 8'd0;
              phase_q   <= PH_INVERSE;
            end
          end
          PH_INVERSE: begin
            phase_q <= (pay_len_q == '0) ? PH_CHECKSUM : PH_PAYLOAD;
          end
          PH_PAYLOAD: begin
            xor_q     <= xor_q ^ rx_byte_i;
            pay_cnt_q <= pay_cnt_inc;
            if (pay_cnt_inc == pay_len_q) begin
              phase_q <= PH_CHECKSUM;
            end
          end
          PH_CHECKSUM: begin
            xor_q   <= xor_q ^ rx_byte_i;
            phase_q <= PH_TRAILER;
          end
          PH_TRAILER: begin
            phase_q     <= PH_IDLE;
            frame_len_q <= 8'd0;
            pay_len_q   <= '0;
            pay_cnt_q   <= '0;
            xor_q       <= 8'd0;
          end
          default: begin
            if (rx_byte_i == start_byte_i) begin
              phase_q     <= PH_LENGTH;
              frame_len_q <= 8'd0;
              pay_len_q   <= '0;
              pay_cnt_q   <= '0;
              xor_q       <= 8'd0;
            end else begin
              phase_q <= PH_IDLE;
            end
          end
        endcase
      end
    end
  end

endmodule

[sv/lpfr_drain.sv]
module lpfr_drain #(
  parameter int unsigned PAYLOAD_MAX = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lpfr_pkg::wr_t         wr_i,
  input  logic                  cmd_valid_i,
  input  lpfr_pkg::cmd_t        cmd_i,
  output logic                  pop_o,
  output lpfr_pkg::drain_stat_t stat_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output lpfr_pkg::kind_e       out_kind_o,
  output logic [7:0]            out_value_o,
  output logic                  out_ok_o,
  output logic                  out_last_o
);

  localparam int unsigned AddrW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;

  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_WAIT} state_e;

  logic [7:0]                store_q [PAYLOAD_MAX];
  logic [7:0]                rd_data_q;
  state_e                    state_q;
  logic [lpfr_pkg::LenW-1:0] idx_q;
  logic [lpfr_pkg::LenW-1:0] len_q;
  logic                      ok_q;
  logic                      out_valid_q;
  lpfr_pkg::kind_e           out_kind_q;
  logic [7:0]                out_value_q;
  logic                      out_ok_q;
  logic                      out_last_q;
  logic                      out_load;
  logic                      slot_free;
  logic                      run_last;

  assign slot_free = !out_valid_q || out_ready_i;
  assign pop_o     = (state_q == ST_IDLE) && cmd_valid_i && slot_free;
  assign run_last  = (idx_q + 1'b1 == len_q);
  assign stat_o.done = (state_q == ST_WAIT) && slot_free && run_last;
  // output register takes a new item this cycle
  assign out_load  = (pop_o && cmd_i.kind != lpfr_pkg::KIND_PAYLOAD) ||
                     ((state_q == ST_WAIT) && slot_free);

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_value_o = out_value_q;
  assign out_ok_o    = out_ok_q;
  assign out_last_o  = out_last_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      store_q[wr_i.addr[AddrW-1:0]] <= wr_i.data;
    end
    if (state_q == ST_READ) begin
      rd_data_q <= store_q[idx_q[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      len_q       <= '0;
      ok_q        <= 1'b0;
      out_valid_q <= 1'b0;
      out_kind_q  <= lpfr_pkg::KIND_DROPPED;
      out_value_q <= 8'd0;
      out_ok_q    <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            if (cmd_i.kind == lpfr_pkg::KIND_PAYLOAD) begin
              len_q   <= cmd_i.len;
              ok_q    <= cmd_i.ok;
              idx_q   <= '0;
              state_q <= ST_READ;
            end else begin
              out_kind_q  <= cmd_i.kind;
              out_value_q <= cmd_i.value;
              out_ok_q    <= cmd_i.ok;
              out_last_q  <= 1'b1;
            end
          end
        end
        ST_READ: begin
          state_q <= ST_WAIT;
        end
        ST_WAIT: begin
          if (slot_free) begin
            out_kind_q  <= lpfr_pkg::KIND_PAYLOAD;
            out_value_q <= rd_data_q;
            out_ok_q    <= ok_q;
            out_last_q  <= run_last;
            if (run_last) begin
              state_q <= ST_IDLE;
            end else begin
              idx_q   <= idx_q + 1'b1;
              state_q <= ST_READ;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

[sv/length_prefixed_frame_receiver_top.sv]
// Length-prefixed frame receiver.
// Input stream (s_axis_*): one received byte per item. A frame is start byte,
// length, inverted length, payload, XOR checksum byte, trailer byte.
// Output stream (m_axis_*): events and payload bytes; tuser carries the kind,
// tlast marks the final item of a run (always set on single events).
// APB port: register 0 (byte address 0) holds the start byte, reset 0.
// Throughput: the parser takes one byte per cycle while s_axis_tready is high.
// A frame's payload run is read out of the payload store byte by byte (store
// read, then output register load); the next byte is read only after the last
// is loaded. While a run is still queued or draining, the parser holds off new
// payload bytes; header and idle bytes keep flowing. An event passes through
// the command queue into the output register; a payload run passes through
// the command queue, a store read and then the output register.
// Reset clears the parser phase, the command queue and the output register;
// the payload store is not cleared and needs no clearing pass.
// When m_axis_tready is low, the result stays in the output register, the
// two-entry command queue fills, and then s_axis_tready drops.
module length_prefixed_frame_receiver_top #(
  parameter int unsigned PAYLOAD_MAX = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] value, [8] checksum_ok, [15:9] zero
  output logic [2:0]  m_axis_tuser,   // [2:0] kind
  output logic        m_axis_tlast
);

  localparam logic [2:0] AddrStartByte = 3'd0;

  logic [7:0]             start_byte_q;
  logic                   push;
  lpfr_pkg::cmd_t         push_cmd;
  lpfr_pkg::cmd_t         pop_cmd;
  logic                   fifo_full;
  logic                   fifo_valid;
  logic                   pop;
  lpfr_pkg::wr_t          wr;
  lpfr_pkg::drain_stat_t  stat;
  lpfr_pkg::kind_e        out_kind;
  logic [7:0]             out_value;
  logic                   out_ok;

  // Configuration: single register, written in the APB access phase
  assign pready = 1'b1;
  assign prdata = (paddr == AddrStartByte) ? {24'd0, start_byte_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= 8'd0;
    end else if (psel && penable && pwrite && pready && paddr == AddrStartByte) begin
      start_byte_q <= pwdata[7:0];
    end
  end

  // Front: frame parser
  lpfr_parser #(.PAYLOAD_MAX(PAYLOAD_MAX)) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_valid_i   (s_axis_tvalid),
    .rx_byte_i    (s_axis_tdata),
    .rx_ready_o   (s_axis_tready),
    .start_byte_i (start_byte_q),
    .fifo_full_i  (fifo_full),
    .push_o       (push),
    .cmd_o        (push_cmd),
    .wr_o         (wr),
    .stat_i       (stat)
  );

  // Command queue between parser and drain
  lpfr_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (fifo_full),
    .pop_i      (pop),
    .valid_o    (fifo_valid),
    .pop_cmd_o  (pop_cmd)
  );

  // Back: payload store and result sequencer
  lpfr_drain #(.PAYLOAD_MAX(PAYLOAD_MAX)) u_drain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr),
    .cmd_valid_i (fifo_valid),
    .cmd_i       (pop_cmd),
    .pop_o       (pop),
    .stat_o      (stat),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (out_kind),
    .out_value_o (out_value),
    .out_ok_o    (out_ok),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tuser = out_kind;
  assign m_axis_tdata = {7'd0, out_ok, out_value};

  // Checks
  a_single_events_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != lpfr_pkg::KIND_PAYLOAD |-> m_axis_tlast)
    else $error("single event without tlast");

  a_events_no_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == lpfr_pkg::KIND_DROPPED ||
                      m_axis_tuser == lpfr_pkg::KIND_MISMATCH ||
                      m_axis_tuser == lpfr_pkg::KIND_BADLEN) |-> !m_axis_tdata[8])
    else $error("checksum flag set on a non-frame event");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !fifo_full)
    else $error("command pushed into a full queue");

  a_store_quiet_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.done |-> !wr.en)
    else $error("payload store written while a run drains");

endmodule

[dv/tb_length_prefixed_frame_receiver_top.sv]
module tb_length_prefixed_frame_receiver_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PayloadMax  = 32;
  localparam int unsigned MaxLen      = PayloadMax + 4;  // largest legal length byte
  localparam int          StallLimit  = 4000;            // cycles with no item moving
  localparam int          QuietCycles = 16;              // settle time before a register write
  localparam int          ReportMax   = 10;
  localparam logic [2:0]  StartByteAddr = 3'd0;

  // Receive phases of the frame parser, kept by the predictor
  typedef enum logic [2:0] {
    RX_IDLE     = 3'd0,
    RX_LENGTH   = 3'd1,
    RX_INVERSE  = 3'd2,
    RX_PAYLOAD  = 3'd3,
    RX_CHECKSUM = 3'd4,
    RX_TRAILER  = 3'd5
  } rx_phase_e;

  // One result item as the output stream carries it
  typedef struct {
    lpfr_pkg::kind_e kind;
    logic [7:0]      value;
    logic            ok;
    logic            last;
  } rx_event_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT ports. Every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // [7:0] rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // [7:0] value, [8] checksum_ok, [15:9] zero
  logic [2:0]  m_axis_tuser;         // [2:0] kind
  logic        m_axis_tlast;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  length_prefixed_frame_receiver_top #(
    .PAYLOAD_MAX(PayloadMax)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // ---------------------------------------------------------------------------
  // Shared testbench state
  // ---------------------------------------------------------------------------
  logic [7:0] rx_bytes_pending[$];   // bytes waiting for the driver
  rx_event_t  frame_events_due[$];   // predicted results, oldest first
  int         pushed_cnt   = 0;
  int         err_cnt      = 0;
  int         result_cnt   = 0;
  int         stall_cnt    = 0;
  int         src_idle_pct = 0;
  int         snk_idle_pct = 0;
  logic       in_fire      = 1'b0;   // set at posedge, read by the driver at negedge
  logic       out_fire     = 1'b0;

  // Predictor copy of the parser state and the start byte register
  logic [7:0] cfg_start_byte;
  rx_phase_e  rx_ph;
  logic [7:0] rx_flen;
  logic [5:0] rx_plen;
  logic [5:0] rx_pcnt;
  logic [7:0] rx_xor;
  logic [7:0] rx_store[64];          // indexed by the 6-bit payload count

  function automatic void log_error(input string msg);
    err_cnt++;
    if (err_cnt <= ReportMax) $display("%s", msg);
  endfunction

  function automatic void add_event(input lpfr_pkg::kind_e k, input logic [7:0] v,
                                    input logic ok, input logic last);
    rx_event_t ev;
    ev.kind  = k;
    ev.value = v;
    ev.ok    = ok;
    ev.last  = last;
    frame_events_due.push_back(ev);
  endfunction

  function automatic void clear_frame();
    rx_ph   = RX_IDLE;
    rx_flen = '0;
    rx_plen = '0;
    rx_pcnt = '0;
    rx_xor  = '0;
  endfunction

  // Advance the parser model by one accepted byte and queue what it emits
  function automatic void predict_frame_byte(input logic [7:0] b);
    logic ok;
    case (rx_ph)
      RX_LENGTH: begin
        rx_flen = b;
        if (b < 8'd4 || b > 8'(MaxLen)) begin
          // bad length: report it and fall back to idle
          add_event(lpfr_pkg::KIND_BADLEN, b, 1'b0, 1'b1);
          clear_frame();
        end else begin
          rx_plen = 6'(b - 8'd4);
          rx_pcnt = '0;
          rx_xor  = '0;
          rx_ph   = RX_INVERSE;
        end
      end
      RX_INVERSE: begin
        // mismatch is only reported, reception goes on
        if ((rx_flen & b) != 8'd0) add_event(lpfr_pkg::KIND_MISMATCH, rx_flen, 1'b0, 1'b1);
        rx_ph = (rx_plen == 6'd0) ? RX_CHECKSUM : RX_PAYLOAD;
      end
      RX_PAYLOAD: begin
        rx_store[rx_pcnt] = b;
        rx_xor  = rx_xor ^ b;
        rx_pcnt = rx_pcnt + 6'd1;
        if (rx_pcnt == rx_plen) rx_ph = RX_CHECKSUM;
      end
      RX_CHECKSUM: begin
        rx_xor = rx_xor ^ b;
        rx_ph  = RX_TRAILER;
      end
      RX_TRAILER: begin
        // trailer value is ignored; it releases the stored payload
        ok = (rx_xor == 8'd0);
        if (rx_plen == 6'd0) begin
          add_event(lpfr_pkg::KIND_EMPTY, 8'd0, ok, 1'b1);
        end else begin
          for (int i = 0; i < int'(rx_plen); i++)
            add_event(lpfr_pkg::KIND_PAYLOAD, rx_store[i], ok, (i + 1 == int'(rx_plen)));
        end
        clear_frame();
      end
      default: begin
        if (b == cfg_start_byte) begin
          clear_frame();
          rx_ph = RX_LENGTH;
        end else begin
          add_event(lpfr_pkg::KIND_DROPPED, b, 1'b0, 1'b1);
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: input bytes and receiver back-pressure, both at the falling edge.
  // tvalid holds until the item is taken; a new byte is only loaded after a
  // handshake or while the bus is idle.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      if (in_fire || !s_axis_tvalid) begin
        if (rx_bytes_pending.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          s_axis_tdata  <= rx_bytes_pending.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: samples both streams at the rising edge, feeds the predictor with
  // accepted bytes and checks accepted results in order. The stall watchdog
  // closes the block so nothing follows its $finish.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    rx_event_t       exp_ev;
    lpfr_pkg::kind_e got_kind;
    in_fire  = rst_ni && s_axis_tvalid && s_axis_tready;
    out_fire = rst_ni && m_axis_tvalid && m_axis_tready;
    if (in_fire) predict_frame_byte(s_axis_tdata);
    if (out_fire) begin
      got_kind = lpfr_pkg::kind_e'(m_axis_tuser);
      if (frame_events_due.size() == 0) begin
        log_error($sformatf("result %0d unexpected: kind %0d value %02h ok %0b last %0b",
                            result_cnt, m_axis_tuser, m_axis_tdata[7:0],
                            m_axis_tdata[8], m_axis_tlast));
      end else begin
        exp_ev = frame_events_due.pop_front();
        if (got_kind !== exp_ev.kind || m_axis_tdata[7:0] !== exp_ev.value ||
            m_axis_tdata[8] !== exp_ev.ok || m_axis_tlast !== exp_ev.last) begin
          log_error($sformatf({"result %0d: expected kind %0d value %02h ok %0b last %0b,",
                               " got kind %0d value %02h ok %0b last %0b"},
                              result_cnt, exp_ev.kind, exp_ev.value, exp_ev.ok,
                              exp_ev.last, m_axis_tuser, m_axis_tdata[7:0],
                              m_axis_tdata[8], m_axis_tlast));
        end
      end
      result_cnt++;
    end
    if (!rst_ni || in_fire || out_fire) stall_cnt = 0;
    else stall_cnt++;
    if (stall_cnt >= StallLimit) begin
      $display("length_prefixed_frame_receiver_top: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void push_byte(input logic [7:0] b);
    rx_bytes_pending.push_back(b);
    pushed_cnt++;
  endfunction

  // APB write of the start byte (setup then access), followed by a readback
  task automatic write_start_byte(input logic [7:0] v);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= StartByteAddr;
    pwdata  <= {24'd0, v};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    cfg_start_byte = v;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[7:0] !== v)
      log_error($sformatf("start byte readback: expected %02h, got %02h", v, prdata[7:0]));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Hold off until every queued byte is taken and every result has come,
  // then let the pipeline settle (frames may end on bytes with no result).
  task automatic wait_drained();
    while (rx_bytes_pending.size() != 0 || s_axis_tvalid || frame_events_due.size() != 0)
      @(posedge clk_i);
    repeat (QuietCycles) @(posedge clk_i);
  endtask

  // One random frame. Mostly well formed with random content; some noise
  // bytes, bad lengths, wrong inverses, bad checksums and cut-off frames.
  task automatic gen_frame();
    int unsigned sel;
    int unsigned npay;
    logic [7:0]  lenb;
    logic [7:0]  b;
    logic [7:0]  x;
    logic        cut;
    sel = $urandom_range(99);
    if (sel < 12) begin
      repeat ($urandom_range(3, 1))
        push_byte(($urandom_range(7) == 0) ? cfg_start_byte : 8'($urandom));
    end else begin
      push_byte(cfg_start_byte);
      sel = $urandom_range(99);
      if (sel < 8)       lenb = 8'($urandom);
      else if (sel < 14) lenb = 8'($urandom_range(3));
      else if (sel < 18) lenb = 8'($urandom_range(255, MaxLen + 1));
      else if (sel < 26) lenb = 8'(MaxLen);
      else if (sel < 32) lenb = 8'd4;
      else               lenb = 8'($urandom_range(12, 5));
      push_byte(lenb);
      if (lenb >= 8'd4 && lenb <= 8'(MaxLen)) begin
        push_byte(($urandom_range(9) == 0) ? 8'($urandom) : ~lenb);
        npay = 32'(lenb - 8'd4);
        cut  = ($urandom_range(19) == 0);
        if (cut) npay = $urandom_range(npay);
        x = '0;
        for (int unsigned i = 0; i < npay; i++) begin
          b = 8'($urandom);
          x = x ^ b;
          push_byte(b);
        end
        // a cut frame leaves the parser mid-frame; later bytes carry on in it
        if (!cut) begin
          push_byte(($urandom_range(3) == 0) ? 8'($urandom) : x);
          push_byte(8'($urandom));
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stim
    logic [7:0] dir_bytes[21];
    int         target;
    cfg_start_byte = '0;
    clear_frame();
    // Directed bytes, start byte 0x00:
    //   two idle drops, length 3, length 0, length 255, length 37 (all bad),
    //   an empty frame with good checksum, and a one-byte frame whose inverse
    //   mismatches and whose payload equals the start byte.
    dir_bytes = '{8'hFF, 8'h5A,
                  8'h00, 8'h03,
                  8'h00, 8'h00,
                  8'h00, 8'hFF,
                  8'h00, 8'h25,
                  8'h00, 8'h04, 8'hFB, 8'h00, 8'h00,
                  8'h00, 8'h05, 8'h05, 8'h00, 8'h00, 8'h00};

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // first mode: sender idles 21%, receiver 46%
    src_idle_pct = 21;
    snk_idle_pct = 46;
    write_start_byte(8'h00);
    foreach (dir_bytes[i]) push_byte(dir_bytes[i]);
    wait_drained();

    write_start_byte(8'hFF);
    target = pushed_cnt + 50;
    while (pushed_cnt < target) gen_frame();
    // sender holds until all results of the first half are out
    wait_drained();
    target = pushed_cnt + 50;
    while (pushed_cnt < target) gen_frame();
    wait_drained();

    // second mode: roles swapped
    src_idle_pct = 46;
    snk_idle_pct = 21;
    write_start_byte(8'($urandom));
    target = pushed_cnt + 100;
    while (pushed_cnt < target) gen_frame();
    wait_drained();

    // third mode: no idling on either side
    src_idle_pct = 0;
    snk_idle_pct = 0;
    write_start_byte(8'($urandom));
    target = pushed_cnt + 100;
    while (pushed_cnt < target) gen_frame();
    wait_drained();

    if (frame_events_due.size() != 0)
      log_error($sformatf("%0d results never arrived", frame_events_due.size()));
    if (err_cnt == 0) begin
      $display("length_prefixed_frame_receiver_top: match");
    end else begin
      $display("length_prefixed_frame_receiver_top: mismatch");
    end
    $finish;
  end

endmodule
